// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, ignored while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on the rising clock at every edge
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/cds_pkg.sv
// Types, constants and month length lookup for the calendar day stepper
package cds_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;

  localparam logic [YearW-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;
  localparam logic [DayW-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DayW-1:0]   DAY_DEC_LAST = 5'd31;

  // Reciprocal of 100 scaled by 2^19, exact for every 14-bit year
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RecipShift = 19;
  localparam logic [6:0]  CENTURY = 7'd100;

  // Direction codes
  localparam logic ACT_NEXT = 1'b0;
  localparam logic ACT_PREV = 1'b1;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct packed {
    logic  action;
    logic  leap;
    date_t date;
  } step_req_t;

  typedef struct packed {
    logic  error;
    date_t date;
  } step_res_t;

  // Days in month m; zero for a code that is no month
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                               input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: sv/cds_step.sv
// Date validation and one-day step, given the leap flag of the year
module cds_step (
  input  cds_pkg::step_req_t req_i,
  output cds_pkg::step_res_t res_o
);

  logic [cds_pkg::DayW-1:0]   len;
  logic [cds_pkg::DayW-1:0]   prev_len;
  logic [cds_pkg::MonthW-1:0] prev_month;
  logic                       bad_in;
  cds_pkg::date_t             d;

  assign prev_month = req_i.date.month - 4'd1;
  assign len        = cds_pkg::month_len(req_i.date.month, req_i.leap);
  assign prev_len   = cds_pkg::month_len(prev_month, req_i.leap);
  assign bad_in     = (req_i.date.year > cds_pkg::YEAR_MAX) || (len == 5'd0) ||
                      (req_i.date.day == 5'd0) || (req_i.date.day > len);

  always_comb begin
    res_o.error = 1'b0;
    d           = req_i.date;
    if (bad_in) begin
      res_o.error = 1'b1;
    end else if (req_i.action == cds_pkg::ACT_NEXT) begin
      if (req_i.date.day < len) begin
        d.day = req_i.date.day + 5'd1;
      end else if (req_i.date.month < cds_pkg::MONTH_DEC) begin
        d.month = req_i.date.month + 4'd1;
        d.day   = cds_pkg::DAY_FIRST;
      end else if (req_i.date.year < cds_pkg::YEAR_MAX) begin
        d.year  = req_i.date.year + 14'd1;
        d.month = cds_pkg::MONTH_JAN;
        d.day   = cds_pkg::DAY_FIRST;
      end else begin
        res_o.error = 1'b1;
      end
    end else begin
      if (req_i.date.day > cds_pkg::DAY_FIRST) begin
        d.day = req_i.date.day - 5'd1;
      end else if (req_i.date.month > cds_pkg::MONTH_JAN) begin
        d.month = prev_month;
        d.day   = prev_len;
      end else if (req_i.date.year != 14'd0) begin
        d.year  = req_i.date.year - 14'd1;
        d.month = cds_pkg::MONTH_DEC;
        d.day   = cds_pkg::DAY_DEC_LAST;
      end else begin
        res_o.error = 1'b1;
      end
    end
    // zero the fields on any error
    res_o.date = res_o.error ? '0 : d;
  end

endmodule

// File: sv/calendar_day_stepper_unit.sv
// Top level: three-stage pipelined Gregorian next/previous day stepper
//
//  channel | handshake       | payload
//  --------+-----------------+------------------------------------------------
//  request | start, busy     | action_i, year_in_i, month_in_i, day_in_i
//  result  | done_o (strobe) | error_o, year_out_o, month_out_o, day_out_o
//
//  One transaction per cycle; busy is always low, since every stage moves on
//  every cycle. A result strobes on done_o as the request leaves stage 3.
//  Stage 1 holds year * (2^19/100), stage 2 the leap flag, stage 3 the result.
//  Reset clears only the stage valid bits. The receiver cannot stall.
`include "assert_macros.svh"

module calendar_day_stepper_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action_i,
  input  logic [cds_pkg::YearW-1:0]    year_in_i,
  input  logic [cds_pkg::MonthW-1:0]   month_in_i,
  input  logic [cds_pkg::DayW-1:0]     day_in_i,
  output logic                         done_o,
  output logic                         error_o,
  output logic [cds_pkg::YearW-1:0]    year_out_o,
  output logic [cds_pkg::MonthW-1:0]   month_out_o,
  output logic [cds_pkg::DayW-1:0]     day_out_o
);

  // stage 1
  logic           s1_vld_q;
  logic           s1_act_q;
  cds_pkg::date_t s1_date_q;
  logic [26:0]    s1_prod_q;
  // stage 2
  logic           s2_vld_q;
  logic           s2_act_q;
  logic           s2_leap_q;
  cds_pkg::date_t s2_date_q;
  // stage 3
  logic               s3_vld_q;
  cds_pkg::step_res_t s3_res_q;

  logic               accept;
  logic [7:0]         quot;
  logic [14:0]        rem;
  logic               div4;
  logic               div100;
  logic               leap_d;
  cds_pkg::step_req_t req;
  cds_pkg::step_res_t res_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // quotient of year / 100 from the reciprocal product
  assign quot   = s1_prod_q[26:cds_pkg::RecipShift];
  assign rem    = {1'b0, s1_date_q.year} - (quot * {1'b0, cds_pkg::CENTURY});
  assign div4   = (s1_date_q.year[1:0] == 2'd0);
  assign div100 = (rem == 15'd0);
  assign leap_d = (div100 && (quot[1:0] == 2'd0)) || (div4 && !div100);

  assign req.action = s2_act_q;
  assign req.leap   = s2_leap_q;
  assign req.date   = s2_date_q;

  cds_step u_step (
    .req_i (req),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_act_q   <= action_i;
    s1_date_q  <= '{year: year_in_i, month: month_in_i, day: day_in_i};
    s1_prod_q  <= {13'd0, year_in_i} * {14'd0, cds_pkg::RECIP_100};
    s2_act_q   <= s1_act_q;
    s2_date_q  <= s1_date_q;
    s2_leap_q  <= leap_d;
    s3_res_q   <= res_d;
  end

  assign done_o      = s3_vld_q;
  assign error_o     = s3_res_q.error;
  assign year_out_o  = s3_res_q.date.year;
  assign month_out_o = s3_res_q.date.month;
  assign day_out_o   = s3_res_q.date.day;

  `ASSERT_RST(a_latency, clk_i, rst_ni, accept |-> ##3 done_o, "result strobe missing after start")
  `ASSERT_RST(a_no_spurious, clk_i, rst_ni, done_o |-> $past(accept, 3), "result without a request")
  `ASSERT_RST(a_err_zero, clk_i, rst_ni, (done_o && error_o) |-> (year_out_o == 14'd0 && month_out_o == 4'd0 && day_out_o == 5'd0), "error result with nonzero fields")
  `ASSERT_RST(a_ok_range, clk_i, rst_ni, (done_o && !error_o) |-> (month_out_o != 4'd0 && month_out_o <= cds_pkg::MONTH_DEC && day_out_o != 5'd0 && year_out_o <= cds_pkg::YEAR_MAX), "valid result out of range")

endmodule
